// ----- design/tcpq_pkg.sv -----
// Shared constants, request codes and controller command type for the two-class priority queue.
package tcpq_pkg;

	// Default sizing of the queue.
	localparam int CAPACITY_DEF = 16;
	localparam int ID_BITS_DEF  = 16;

	// Widths of the transaction fields.
	localparam int REQ_W   = 2;
	localparam int IDW     = 16;
	localparam int COUNT_W = 5;

	// Request codes.
	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT   = 2'd0,
		REQ_SERVE    = 2'd1,
		REQ_WITHDRAW = 2'd2,
		REQ_QUERY    = 2'd3
	} req_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

endpackage

// ----- design/tcpq_ctrl.sv -----
// Controller state machine: sequences request capture, commit and the result handshake.
module tcpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output tcpq_pkg::dp_cmd_t cmd
);
	import tcpq_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// A request is taken only when no other is in flight.
	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = in_valid && in_ready;
	// The update is applied once the result register is free or being emptied.
	assign cmd.commit  = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	// State and the registered result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/tcpq_datapath.sv -----
// Datapath: shift-register cell chain with parallel id compare, counters and result register.
module tcpq_datapath #(
	parameter int CAPACITY = tcpq_pkg::CAPACITY_DEF,
	parameter int ID_BITS  = tcpq_pkg::ID_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcpq_pkg::dp_cmd_t            cmd,
	input  logic [tcpq_pkg::REQ_W-1:0]   req_type,
	input  logic [tcpq_pkg::IDW-1:0]     id,
	input  logic                         preferred,
	output logic                         ok,
	output logic [tcpq_pkg::IDW-1:0]     served_id,
	output logic                         class_flag,
	output logic [tcpq_pkg::COUNT_W-1:0] count
);
	import tcpq_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	// Cell chain; slot 0 is the head. Only slots below the count are meaningful.
	logic [ID_BITS-1:0] cell_id_q  [CAPACITY];
	logic               cell_cls_q [CAPACITY];
	logic [ID_BITS-1:0] cell_id_d  [CAPACITY];
	logic               cell_cls_d [CAPACITY];

	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       pref_q, pref_d;

	// Request captured with its match vector.
	req_t                req_q;
	logic [ID_BITS-1:0]  key_q;
	logic                pref_in_q;
	logic [CAPACITY-1:0] match_q;

	// Result register.
	logic                ok_q;
	logic [ID_BITS-1:0]  served_q;
	logic                cls_q;
	logic [CW-1:0]       res_count_q;

	logic [ID_BITS-1:0]  key_in;
	logic [CAPACITY-1:0] match_in;

	logic                found;
	logic                found_cls;
	logic [IW-1:0]       found_pos;
	logic                full;
	logic                do_insert;
	logic                do_remove;
	logic [CW-1:0]       ins_pos;
	logic [CW-1:0]       rem_pos;
	logic                rem_cls;
	logic                ok_d;
	logic [ID_BITS-1:0]  served_d;
	logic                cls_d;

	assign key_in = ID_BITS'(id);

	// Every occupied cell compares its id with the incoming key at once.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match_in[i] = (cell_id_q[i] == key_in) && (CW'(i) < count_q);
		end
	end

	// Ids are unique, so at most one cell matches: the position is an OR encode.
	always_comb begin
		found     = |match_q;
		found_cls = 1'b0;
		found_pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			found_cls = found_cls | (match_q[i] & cell_cls_q[i]);
			if (match_q[i]) begin
				found_pos = found_pos | IW'(i);
			end
		end
	end

	// Decide the operation and its result.
	always_comb begin
		full      = (count_q == CW'(CAPACITY));
		do_insert = 1'b0;
		do_remove = 1'b0;
		ins_pos   = pref_in_q ? pref_q : count_q;
		rem_pos   = '0;
		rem_cls   = cell_cls_q[0];
		ok_d      = 1'b0;
		served_d  = '0;
		cls_d     = 1'b0;
		case (req_q)
			REQ_INSERT: begin
				do_insert = !full && !found;
				ok_d      = do_insert;
			end
			REQ_SERVE: begin
				do_remove = (count_q != '0);
				ok_d      = do_remove;
				if (do_remove) begin
					served_d = cell_id_q[0];
					cls_d    = cell_cls_q[0];
				end
			end
			REQ_WITHDRAW: begin
				do_remove = found;
				ok_d      = found;
				rem_pos   = CW'(found_pos);
				rem_cls   = found_cls;
			end
			default: begin
				ok_d  = found;
				cls_d = found_cls;
			end
		endcase
	end

	// Next contents of the chain: open a gap for an insert, close one for a removal.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_id_d[i]  = cell_id_q[i];
			cell_cls_d[i] = cell_cls_q[i];
		end
		if (do_insert) begin
			for (int i = 1; i < CAPACITY; i++) begin
				if ((CW'(i) > ins_pos) && (CW'(i) <= count_q)) begin
					cell_id_d[i]  = cell_id_q[i-1];
					cell_cls_d[i] = cell_cls_q[i-1];
				end
			end
			for (int i = 0; i < CAPACITY; i++) begin
				if (CW'(i) == ins_pos) begin
					cell_id_d[i]  = key_q;
					cell_cls_d[i] = pref_in_q;
				end
			end
		end else if (do_remove) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if ((CW'(i) >= rem_pos) && (CW'(i + 1) < count_q)) begin
					cell_id_d[i]  = cell_id_q[i+1];
					cell_cls_d[i] = cell_cls_q[i+1];
				end
			end
		end
	end

	// Counter updates.
	always_comb begin
		count_d = count_q;
		pref_d  = pref_q;
		if (do_insert) begin
			count_d = count_q + CW'(1);
			if (pref_in_q) begin
				pref_d = pref_q + CW'(1);
			end
		end else if (do_remove) begin
			count_d = count_q - CW'(1);
			if (rem_cls && (pref_q != '0)) begin
				pref_d = pref_q - CW'(1);
			end
		end
	end

	// Counters are control state and are cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pref_q  <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
			pref_q  <= pref_d;
		end
	end

	// Payload registers: captured request, cells and result.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q     <= req_t'(req_type);
			key_q     <= key_in;
			pref_in_q <= preferred;
			match_q   <= match_in;
		end
		if (cmd.commit) begin
			for (int i = 0; i < CAPACITY; i++) begin
				cell_id_q[i]  <= cell_id_d[i];
				cell_cls_q[i] <= cell_cls_d[i];
			end
			ok_q        <= ok_d;
			served_q    <= served_d;
			cls_q       <= cls_d;
			res_count_q <= count_d;
		end
	end

	assign ok         = ok_q;
	assign served_id  = IDW'(served_q);
	assign class_flag = cls_q;
	assign count      = COUNT_W'(res_count_q);

endmodule

// ----- design/two_class_priority_queue_top.sv -----
// Two-class priority queue of unique ids (preferred before ordinary, each first in, first out).
//
// Usage: a request transaction (req_type, id, preferred) is taken on the input channel
// when in_valid and in_ready are both high; exactly one result transaction (ok,
// served_id, class_flag, count) follows on the output channel for every request.
// Requests: insert, serve head, withdraw an id, query the class of an id.
// Steps: in the cycle of acceptance every cell of the shift-register chain compares its
// id with the key and the match vector is registered; then, once the result register
// is free or being emptied, the chain is updated (an insert or a removal shifts part of
// it by one place) and the result register is loaded.
// Requests are handled one at a time by the controller: a new request is taken only
// after the update of the previous one has been applied.
// Stalls: the result waits in its own register while out_ready is low; the next
// request is still taken and compared, and its update is held until the pending
// result is taken.
// Reset: arst_n clears the entry and preferred counts, so the queue is empty; no
// clearing pass is needed and a request can be taken as soon as reset is released.
module two_class_priority_queue_top #(
	parameter int CAPACITY = tcpq_pkg::CAPACITY_DEF,
	parameter int ID_BITS  = tcpq_pkg::ID_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tcpq_pkg::REQ_W-1:0]   req_type,
	input  logic [tcpq_pkg::IDW-1:0]     id,
	input  logic                         preferred,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         ok,
	output logic [tcpq_pkg::IDW-1:0]     served_id,
	output logic                         class_flag,
	output logic [tcpq_pkg::COUNT_W-1:0] count
);
	import tcpq_pkg::*;

	dp_cmd_t cmd;

	// Sequencing of capture, commit and the result handshake.
	tcpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Cell chain, counters and result register.
	tcpq_datapath #(
		.CAPACITY (CAPACITY),
		.ID_BITS  (ID_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req_type   (req_type),
		.id         (id),
		.preferred  (preferred),
		.ok         (ok),
		.served_id  (served_id),
		.class_flag (class_flag),
		.count      (count)
	);

endmodule
